[hdl/assert_macros.svh]
// Assertion macros for the Chebyshev evaluator RTL.
// Included by modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

[hdl/cheb_pkg.sv]
// Shared widths, constants, codes and sequencer types of the Chebyshev evaluator.
// No dependencies; used by chebyshev_polynomial_evaluator.
package cheb_pkg;

  localparam int FRAC_BITS  = 30;
  localparam int MAX_DEGREE = 63;

  localparam int ACT_W   = 2;
  localparam int DEG_W   = 6;
  localparam int POINT_W = 32;
  localparam int VAL_W   = 63;

  localparam int IN_TDATA_W  = ((DEG_W + POINT_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VAL_W + 7) / 8) * 8;

  // Multiplier: signed operand A up to 2x (one more bit than x), operand B a value.
  localparam int OPA_W  = POINT_W + 1;
  localparam int LO_W   = 32;
  localparam int HI_W   = VAL_W - LO_W;
  localparam int MUL_W  = OPA_W + LO_W;
  localparam int PROD_W = OPA_W + VAL_W;

  // Step counter holds up to MAX_DEGREE + 1.
  localparam int CNT_W = $clog2(MAX_DEGREE + 2);

  // Restoring divider over |num| * 2^FRAC_BITS.
  localparam int DIV_BITS = VAL_W + FRAC_BITS;
  localparam int DCNT_W   = $clog2(DIV_BITS);
  localparam int REM_W    = VAL_W + 1;
  localparam int QUO_W    = 64;

  localparam logic [VAL_W-1:0] VMAX   = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VMIN   = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] ONE_FX = VAL_W'(1) << FRAC_BITS;

  localparam logic [PROD_W-1:0] LIM_P  = PROD_W'(1) << (VAL_W - 1);
  localparam logic [PROD_W-1:0] VMAX_P = LIM_P - PROD_W'(1);
  localparam logic [PROD_W-1:0] OVF_P  = LIM_P << 1;
  localparam logic [PROD_W-1:0] HALF_P = PROD_W'(1) << (FRAC_BITS - 1);

  localparam logic [ACT_W-1:0] ACT_T  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_U  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DU = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OPS,
    S_MLO,
    S_MHI,
    S_ACC,
    S_RND,
    S_SUB,
    S_DLOAD,
    S_DIV,
    S_DRND,
    S_DSAT,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    PH_DEN,
    PH_TREC,
    PH_UREC,
    PH_KT,
    PH_XU
  } phase_e;

endpackage

[hdl/chebyshev_polynomial_evaluator.sv]
// Chebyshev T_n, U_n and dU_n/dx evaluator: top level, single module.
// Depends on cheb_pkg (hdl/cheb_pkg.sv) and assert_macros.svh.
//
//   channel  | dir | tdata (low bit up)          | tuser
//   ---------+-----+-----------------------------+---------------
//   s_axis   | in  | degree[5:0], point[37:6]    | action[1:0]
//   m_axis   | out | value[62:0], zero pad [63]  | status[0]
//
// Every fixed-point product runs on one 33x32 multiplier through operand load,
// low half, high half, accumulate, round/saturate and subtract. dU_n/dx runs
// T_{n+1} and U_n before the one-bit-per-cycle restoring divider; an endpoint
// derivative stops once x^2 - 1 comes out zero.
// One item at a time: s_axis_tready is high only while the sequencer is idle.
// The result sits in an output register, so a stalled m_axis holds the sequencer
// in its done state only once the next result is ready as well.
// Reset is asynchronous, active low; no clearing pass.

`include "assert_macros.svh"

module chebyshev_polynomial_evaluator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // degree [5:0], point [37:6], zeros above
  input  logic [cheb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // action [1:0]
  input  logic [cheb_pkg::ACT_W-1:0]          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // value [62:0], zero [63]
  output logic [cheb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // status [0]
  output logic                                m_axis_tuser
);

  localparam int VAL_W  = cheb_pkg::VAL_W;
  localparam int OPA_W  = cheb_pkg::OPA_W;
  localparam int PROD_W = cheb_pkg::PROD_W;
  localparam int CNT_W  = cheb_pkg::CNT_W;
  localparam int REM_W  = cheb_pkg::REM_W;

  // Saturate a sign and magnitude to the 63-bit value range.
  function automatic logic [VAL_W-1:0] sat_mag(input logic neg,
                                               input logic [PROD_W-1:0] m);
    logic [VAL_W-1:0] r;
    if (neg) begin
      r = (m >= cheb_pkg::LIM_P) ? cheb_pkg::VMIN : VAL_W'(0) - m[VAL_W-1:0];
    end else begin
      r = (m > cheb_pkg::VMAX_P) ? cheb_pkg::VMAX : m[VAL_W-1:0];
    end
    return r;
  endfunction

  // Saturate a one-bit-wider difference back to the value range.
  function automatic logic [VAL_W-1:0] sat_diff(input logic [VAL_W:0] d);
    logic [VAL_W-1:0] r;
    if (d[VAL_W] != d[VAL_W-1]) begin
      r = d[VAL_W] ? cheb_pkg::VMIN : cheb_pkg::VMAX;
    end else begin
      r = d[VAL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] mag63(input logic [VAL_W-1:0] v);
    return v[VAL_W-1] ? VAL_W'(0) - v : v;
  endfunction

  // ---------------------------------------------------------------------------
  // Control state
  cheb_pkg::state_e state_q, state_d;
  cheb_pkg::phase_e phase_q, phase_d;
  logic             out_valid_q;

  // Item and recurrence registers
  logic [cheb_pkg::ACT_W-1:0]   action_q;
  logic [cheb_pkg::POINT_W-1:0] x_q;
  logic [CNT_W-1:0]             n_q;
  logic [CNT_W-1:0]             cnt_q;
  logic [VAL_W-1:0]             a_q;    // p_{j-2}; later the numerator
  logic [VAL_W-1:0]             b_q;    // p_{j-1}; holds U_n through the tail
  logic [VAL_W-1:0]             t_q;    // T_{n+1}, then (n+1) T_{n+1}
  logic [VAL_W-1:0]             den_q;  // x^2 - 1
  logic [VAL_W-1:0]             value_q;
  logic                         status_q;

  // Shared multiplier path
  logic [OPA_W-1:0]             amag_q;
  logic [VAL_W-1:0]             bmag_q;
  logic                         neg_q;
  logic                         round_q;
  logic [cheb_pkg::MUL_W-1:0]   pp0_q, pp1_q;
  logic [PROD_W-1:0]            sum_q;
  logic [VAL_W-1:0]             r_q;

  // Divider
  logic [cheb_pkg::DIV_BITS-1:0] dvd_q;
  logic [VAL_W-1:0]              dsor_q;
  logic [REM_W-1:0]              rem_q;
  logic [cheb_pkg::QUO_W-1:0]    quo_q;
  logic                          over_q;
  logic [cheb_pkg::DCNT_W-1:0]   dcnt_q;

  // Output register
  logic [VAL_W-1:0] out_value_q;
  logic             out_status_q;

  // ---------------------------------------------------------------------------
  // Input unpacking
  logic [cheb_pkg::DEG_W-1:0]   deg_in;
  logic [cheb_pkg::POINT_W-1:0] point_in;
  logic [CNT_W-1:0]             n_in;
  logic [VAL_W-1:0]             point_ext;
  logic                         in_fire;

  assign deg_in    = s_axis_tdata[cheb_pkg::DEG_W-1:0];
  assign point_in  = s_axis_tdata[cheb_pkg::DEG_W +: cheb_pkg::POINT_W];
  assign n_in      = (CNT_W'(deg_in) > CNT_W'(cheb_pkg::MAX_DEGREE)) ?
                     CNT_W'(cheb_pkg::MAX_DEGREE) : CNT_W'(deg_in);
  assign point_ext = {{(VAL_W-cheb_pkg::POINT_W){point_in[cheb_pkg::POINT_W-1]}}, point_in};
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Operand selection for the shared multiplier
  logic [VAL_W-1:0] x_ext;
  logic [OPA_W-1:0] x_a, x2_a, k_a;
  logic [OPA_W-1:0] opa;
  logic [VAL_W-1:0] opb;
  logic             op_round;
  logic             rec_fin;

  assign x_ext = {{(VAL_W-cheb_pkg::POINT_W){x_q[cheb_pkg::POINT_W-1]}}, x_q};
  assign x_a   = {x_q[cheb_pkg::POINT_W-1], x_q};
  assign x2_a  = {x_q, 1'b0};
  assign k_a   = OPA_W'(n_q) + OPA_W'(1);

  assign rec_fin = ((phase_q == cheb_pkg::PH_TREC) || (phase_q == cheb_pkg::PH_UREC)) &&
                   (cnt_q == '0);

  always_comb begin
    case (phase_q) inside
      cheb_pkg::PH_TREC, cheb_pkg::PH_UREC: begin
        opa = x2_a;  opb = b_q;   op_round = 1'b1;
      end
      cheb_pkg::PH_KT: begin
        opa = k_a;   opb = t_q;   op_round = 1'b0;
      end
      cheb_pkg::PH_XU: begin
        opa = x_a;   opb = b_q;   op_round = 1'b1;
      end
      default: begin
        opa = x_a;   opb = x_ext; op_round = 1'b1;
      end
    endcase
  end

  // One multiplier, fed the low then the high half of |B|
  logic [cheb_pkg::LO_W-1:0]  mul_chunk;
  logic [cheb_pkg::MUL_W-1:0] mul_p;

  assign mul_chunk = (state_q == cheb_pkg::S_MHI) ?
                     cheb_pkg::LO_W'(bmag_q[VAL_W-1:cheb_pkg::LO_W]) :
                     bmag_q[cheb_pkg::LO_W-1:0];
  assign mul_p     = cheb_pkg::MUL_W'(amag_q) * cheb_pkg::MUL_W'(mul_chunk);

  // Subtract stage: r - p_{j-2}, r - 1, r, or kt - r depending on phase
  logic [VAL_W:0]   diff;
  logic [VAL_W-1:0] sub_c;

  always_comb begin
    case (phase_q)
      cheb_pkg::PH_DEN:  diff = {r_q[VAL_W-1], r_q} - {1'b0, cheb_pkg::ONE_FX};
      cheb_pkg::PH_KT:   diff = {r_q[VAL_W-1], r_q};
      cheb_pkg::PH_XU:   diff = {t_q[VAL_W-1], t_q} - {r_q[VAL_W-1], r_q};
      default:           diff = {r_q[VAL_W-1], r_q} - {a_q[VAL_W-1], a_q};
    endcase
  end

  assign sub_c = sat_diff(diff);

  // Divider step
  logic [REM_W-1:0] rem_sh, rem_nx;
  logic             div_ge, div_rnd;

  assign rem_sh  = {rem_q[REM_W-2:0], dvd_q[cheb_pkg::DIV_BITS-1]};
  assign div_ge  = rem_sh >= REM_W'(dsor_q);
  assign rem_nx  = div_ge ? rem_sh - REM_W'(dsor_q) : rem_sh;
  assign div_rnd = {rem_q, 1'b0} >= (REM_W + 1)'(dsor_q);

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    unique case (state_q)
      cheb_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (s_axis_tuser)
            cheb_pkg::ACT_T:  begin state_d = cheb_pkg::S_OPS; phase_d = cheb_pkg::PH_TREC; end
            cheb_pkg::ACT_U:  begin state_d = cheb_pkg::S_OPS; phase_d = cheb_pkg::PH_UREC; end
            cheb_pkg::ACT_DU: begin state_d = cheb_pkg::S_OPS; phase_d = cheb_pkg::PH_DEN;  end
            default:          state_d = cheb_pkg::S_DONE;
          endcase
        end
      end
      cheb_pkg::S_OPS: begin
        if (!rec_fin) begin
          state_d = cheb_pkg::S_MLO;
        end else if (action_q != cheb_pkg::ACT_DU) begin
          state_d = cheb_pkg::S_DONE;
        end else if (phase_q == cheb_pkg::PH_TREC) begin
          phase_d = cheb_pkg::PH_UREC;
        end else begin
          phase_d = cheb_pkg::PH_KT;
        end
      end
      cheb_pkg::S_MLO: state_d = cheb_pkg::S_MHI;
      cheb_pkg::S_MHI: state_d = cheb_pkg::S_ACC;
      cheb_pkg::S_ACC: state_d = cheb_pkg::S_RND;
      cheb_pkg::S_RND: state_d = cheb_pkg::S_SUB;
      cheb_pkg::S_SUB: begin
        unique case (phase_q)
          cheb_pkg::PH_DEN: begin
            if (sub_c == '0) begin
              state_d = cheb_pkg::S_DONE;
            end else begin
              state_d = cheb_pkg::S_OPS;
              phase_d = cheb_pkg::PH_TREC;
            end
          end
          cheb_pkg::PH_KT: begin
            state_d = cheb_pkg::S_OPS;
            phase_d = cheb_pkg::PH_XU;
          end
          cheb_pkg::PH_XU: state_d = cheb_pkg::S_DLOAD;
          default:         state_d = cheb_pkg::S_OPS;
        endcase
      end
      cheb_pkg::S_DLOAD: state_d = cheb_pkg::S_DIV;
      cheb_pkg::S_DIV:   if (dcnt_q == '0) state_d = cheb_pkg::S_DRND;
      cheb_pkg::S_DRND:  state_d = cheb_pkg::S_DSAT;
      cheb_pkg::S_DSAT:  state_d = cheb_pkg::S_DONE;
      cheb_pkg::S_DONE: begin
        if (!out_valid_q || m_axis_tready) state_d = cheb_pkg::S_IDLE;
      end
      default: state_d = cheb_pkg::S_IDLE;
    endcase
  end

  // Sequencer: outputs
  logic load_out;

  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    unique case (state_q)
      cheb_pkg::S_IDLE: s_axis_tready = 1'b1;
      cheb_pkg::S_DONE: load_out      = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cheb_pkg::S_IDLE;
      phase_q     <= cheb_pkg::PH_DEN;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      cheb_pkg::S_IDLE: begin
        if (in_fire) begin
          action_q <= s_axis_tuser;
          x_q      <= point_in;
          n_q      <= n_in;
          cnt_q    <= n_in;
          status_q <= 1'b0;
          value_q  <= '0;
          // Seed p_{-1} so that the first step yields p_1: x for T, 0 for U
          a_q      <= (s_axis_tuser == cheb_pkg::ACT_T) ? point_ext : '0;
          b_q      <= cheb_pkg::ONE_FX;
        end
      end
      cheb_pkg::S_OPS: begin
        if (rec_fin) begin
          value_q <= b_q;
          if (phase_q == cheb_pkg::PH_TREC) begin
            // Hand T_{n+1} over and restart for U_n
            t_q   <= b_q;
            a_q   <= '0;
            b_q   <= cheb_pkg::ONE_FX;
            cnt_q <= n_q;
          end
        end else begin
          amag_q  <= opa[OPA_W-1] ? OPA_W'(0) - opa : opa;
          bmag_q  <= mag63(opb);
          neg_q   <= opa[OPA_W-1] ^ opb[VAL_W-1];
          round_q <= op_round;
        end
      end
      cheb_pkg::S_MLO: pp0_q <= mul_p;
      cheb_pkg::S_MHI: pp1_q <= mul_p;
      cheb_pkg::S_ACC: begin
        sum_q <= PROD_W'(pp0_q) + (PROD_W'(pp1_q) << cheb_pkg::LO_W) +
                 (round_q ? cheb_pkg::HALF_P : PROD_W'(0));
      end
      cheb_pkg::S_RND: begin
        r_q <= sat_mag(neg_q, round_q ? (sum_q >> cheb_pkg::FRAC_BITS) : sum_q);
      end
      cheb_pkg::S_SUB: begin
        case (phase_q)
          cheb_pkg::PH_DEN: begin
            den_q <= sub_c;
            if (sub_c == '0) begin
              status_q <= 1'b1;
              value_q  <= '0;
            end
            a_q   <= x_ext;
            b_q   <= cheb_pkg::ONE_FX;
            cnt_q <= n_q + CNT_W'(1);
          end
          cheb_pkg::PH_KT: t_q <= sub_c;
          cheb_pkg::PH_XU: a_q <= sub_c;
          default: begin
            a_q   <= b_q;
            b_q   <= sub_c;
            cnt_q <= cnt_q - CNT_W'(1);
          end
        endcase
      end
      cheb_pkg::S_DLOAD: begin
        neg_q  <= a_q[VAL_W-1] ^ den_q[VAL_W-1];
        dvd_q  <= {mag63(a_q), {cheb_pkg::FRAC_BITS{1'b0}}};
        dsor_q <= mag63(den_q);
        rem_q  <= '0;
        quo_q  <= '0;
        over_q <= 1'b0;
        dcnt_q <= cheb_pkg::DCNT_W'(cheb_pkg::DIV_BITS - 1);
      end
      cheb_pkg::S_DIV: begin
        dvd_q  <= dvd_q << 1;
        rem_q  <= rem_nx;
        quo_q  <= {quo_q[cheb_pkg::QUO_W-2:0], div_ge};
        // Quotient bits about to leave the 63-bit range: saturate later
        if (quo_q[cheb_pkg::QUO_W-1:cheb_pkg::QUO_W-2] != '0) over_q <= 1'b1;
        dcnt_q <= dcnt_q - cheb_pkg::DCNT_W'(1);
      end
      cheb_pkg::S_DRND: begin
        sum_q <= over_q ? cheb_pkg::OVF_P :
                 PROD_W'(quo_q) + PROD_W'(div_rnd);
      end
      cheb_pkg::S_DSAT: value_q <= sat_mag(neg_q, sum_q);
      default: ;
    endcase

    if (load_out) begin
      out_value_q  <= value_q;
      out_status_q <= status_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = cheb_pkg::OUT_TDATA_W'(out_value_q);
  assign m_axis_tuser  = out_status_q;

  // ---------------------------------------------------------------------------
  // Checks
  `ASSERT_CLK(a_status_zero, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0), "endpoint status with nonzero value")
  `ASSERT_NEXT(a_one_item, in_fire, !s_axis_tready, "second item taken while busy")
  `ASSERT_CLK(a_status_deriv, (load_out && status_q) |-> (action_q == cheb_pkg::ACT_DU), "status set outside derivative")
  `ASSERT_NEXT(a_div_len, (state_q == cheb_pkg::S_DIV) && (dcnt_q != '0), state_q == cheb_pkg::S_DIV, "divider left early")

endmodule

[dv/tb_top.sv]
// Self-checking testbench for chebyshev_polynomial_evaluator: T_n, U_n and dU_n/dx items.
// Depends on cheb_pkg for widths and action codes; needs only the RTL to build.
// A queue-fed driver and a checking monitor run as clocked blocks against a bit-exact predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int ACT_W       = cheb_pkg::ACT_W;
  localparam int DEG_W       = cheb_pkg::DEG_W;
  localparam int POINT_W     = cheb_pkg::POINT_W;
  localparam int VAL_W       = cheb_pkg::VAL_W;
  localparam int IN_TDATA_W  = cheb_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = cheb_pkg::OUT_TDATA_W;
  localparam int FRAC_BITS   = cheb_pkg::FRAC_BITS;
  localparam int MAX_DEGREE  = cheb_pkg::MAX_DEGREE;

  // Signed fixed-point value at predictor width; results stay within +-2^62.
  typedef logic signed [63:0] fx_t;

  typedef struct {
    logic [ACT_W-1:0]   action;
    logic [DEG_W-1:0]   degree;
    logic [POINT_W-1:0] point;
    bit                 sync;    // hold this item until every earlier result is back
  } cheb_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             status;
  } cheb_result_t;

  // Action 3 has no package name; it must return zero with status clear.
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

  localparam logic [127:0] MAG_LIM = 128'd1 << (VAL_W - 1);
  localparam fx_t VAL_HI = fx_t'(MAG_LIM - 128'd1);
  localparam fx_t VAL_LO = -fx_t'(MAG_LIM);
  localparam fx_t FX_ONE = fx_t'(64'd1 << FRAC_BITS);

  localparam logic [POINT_W-1:0] PT_ONE     = POINT_W'(1) << FRAC_BITS;
  localparam logic [POINT_W-1:0] PT_NEG_ONE = -PT_ONE;
  localparam logic [POINT_W-1:0] PT_HALF    = POINT_W'(1) << (FRAC_BITS - 1);

  localparam int NUM_RANDOM = 900;
  // Slowest item: top-degree derivative.
  localparam int DRAIN_CYCLES = 1000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int HOLD_AFTER   = 40;
  localparam int unsigned CYCLE_LIMIT = 5_000_000;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // degree [5:0], point [37:6], zeros above
  logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
  // action [1:0]
  logic [ACT_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // value [62:0], zero [63]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // status [0]
  logic                  m_axis_tuser;

  cheb_item_t   stim_items_q[$];
  cheb_result_t poly_results_q[$];
  cheb_item_t   next_item;

  int          total_items  = 1;
  int          accepted_cnt = 0;
  int          mismatch_cnt = 0;
  int          hold_left    = 0;
  bit          hold_used    = 1'b0;
  int unsigned cycle_cnt    = 0;

  chebyshev_polynomial_evaluator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the block: round to nearest, ties away from zero,
  // saturate every intermediate to [-2^62, 2^62-1].
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] mag64(fx_t v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Apply a sign to a wide magnitude and clamp to the value range.
  function automatic fx_t clamp_mag(bit neg, logic [127:0] m);
    if (neg)
      return (m >= MAG_LIM) ? VAL_LO : -fx_t'(m);
    return (m >= MAG_LIM) ? VAL_HI : fx_t'(m);
  endfunction

  function automatic fx_t fx_sum(fx_t a, fx_t b);
    fx_t s;
    s = a + b;
    if (s > VAL_HI) return VAL_HI;
    if (s < VAL_LO) return VAL_LO;
    return s;
  endfunction

  function automatic fx_t fx_product(fx_t a, fx_t b);
    logic [127:0] p;
    p = 128'(mag64(a)) * 128'(mag64(b)) + (128'd1 << (FRAC_BITS - 1));
    return clamp_mag((a < 0) != (b < 0), p >> FRAC_BITS);
  endfunction

  // num * 2^FRAC_BITS / den, rounded half away; den is never zero here.
  function automatic fx_t fx_quotient(fx_t num, fx_t den);
    logic [127:0] dvd, dvs, q, r;
    dvs = 128'(mag64(den));
    dvd = 128'(mag64(num)) << FRAC_BITS;
    q   = dvd / dvs;
    r   = dvd % dvs;
    // An overflowing quotient saturates before any rounding.
    if (q < (128'd1 << 63) && r >= dvs - r)
      q = q + 128'd1;
    return clamp_mag((num < 0) != (den < 0), q);
  endfunction

  // p_k of p_j = 2x p_{j-1} - p_{j-2}, with p_0 = 1 and p_1 = p1.
  function automatic fx_t cheb_recur(fx_t p1, fx_t x, int unsigned k);
    fx_t a, b, c, x2;
    a  = FX_ONE;
    b  = p1;
    x2 = x * 2;
    if (k == 0) return a;
    for (int unsigned j = 2; j <= k; j++) begin
      c = fx_sum(fx_product(x2, b), -a);
      a = b;
      b = c;
    end
    return b;
  endfunction

  function automatic cheb_result_t eval_cheb(logic [ACT_W-1:0] act, logic [DEG_W-1:0] deg,
                                             logic [POINT_W-1:0] pt);
    cheb_result_t res;
    fx_t          x, v, den, t, u, kt, num;
    int unsigned  n;
    x = fx_t'($signed(pt));
    n = 32'(deg);
    if (n > MAX_DEGREE) n = MAX_DEGREE;
    v = '0;
    res.status = 1'b0;
    case (act)
      cheb_pkg::ACT_T: v = cheb_recur(x, x, n);
      cheb_pkg::ACT_U: v = cheb_recur(x * 2, x, n);
      cheb_pkg::ACT_DU: begin
        den = fx_sum(fx_product(x, x), -FX_ONE);
        if (den == 0) begin
          // Endpoint: flag it and return zero instead of dividing.
          res.status = 1'b1;
        end else begin
          t   = cheb_recur(x, x, n + 1);
          u   = cheb_recur(x * 2, x, n);
          kt  = clamp_mag(t < 0, 128'(mag64(t)) * 128'(n + 1));
          num = fx_sum(kt, -fx_product(x, u));
          v   = fx_quotient(num, den);
        end
      end
      default: v = '0;
    endcase
    res.value = v[VAL_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle profile: first sender 13% / receiver 48%, then swapped, then none.
  // ---------------------------------------------------------------------------
  function automatic int send_idle_pct();
    case ((accepted_cnt * 3) / total_items)
      0:       return 13;
      1:       return 48;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct();
    case ((accepted_cnt * 3) / total_items)
      0:       return 48;
      1:       return 13;
      default: return 0;
    endcase
  endfunction

  task automatic add_item(logic [ACT_W-1:0] act, logic [DEG_W-1:0] deg,
                          logic [POINT_W-1:0] pt, bit sync);
    cheb_item_t it;
    it.action = act;
    it.degree = deg;
    it.point  = pt;
    it.sync   = sync;
    stim_items_q.push_back(it);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer the head of the stimulus queue, predict on acceptance.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      accepted_cnt  <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        // Predict from the fields exactly as the block saw them.
        poly_results_q.push_back(eval_cheb(s_axis_tuser, s_axis_tdata[DEG_W-1:0],
                                           s_axis_tdata[DEG_W +: POINT_W]));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        // A sync item waits until the block has handed back everything.
        if (stim_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct() &&
            !(stim_items_q[0].sync && poly_results_q.size() != 0)) begin
          next_item = stim_items_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= IN_TDATA_W'({next_item.point, next_item.degree});
          s_axis_tuser  <= next_item.action;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure plus one long hold-off early in the run,
  // long enough that the block finishes its next item and stalls its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_used     <= 1'b0;
    end else if (!hold_used && accepted_cnt >= HOLD_AFTER) begin
      hold_used     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result item against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (poly_results_q.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 50)
          $display("%0t: unexpected result: expected none, actual value %h status %0d",
                   $time, m_axis_tdata, m_axis_tuser);
      end else begin
        if (m_axis_tdata !== {1'b0, poly_results_q[0].value} ||
            m_axis_tuser !== poly_results_q[0].status) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 50)
            $display("%0t: result mismatch: expected value %h status %0d, actual value %h status %0d",
                     $time, {1'b0, poly_results_q[0].value}, poly_results_q[0].status,
                     m_axis_tdata, m_axis_tuser);
        end
        void'(poly_results_q.pop_front());
      end
    end
  end

  // Hard stop if the run hangs.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int                 sel;
    logic [ACT_W-1:0]   act;
    logic [DEG_W-1:0]   deg;
    logic [POINT_W-1:0] pt;

    // Directed: degree and point extremes, every action, the endpoint
    // derivative, points outside -1..1 and the unused action.
    add_item(cheb_pkg::ACT_T,  6'd0,  PT_ONE,         1'b0);
    add_item(cheb_pkg::ACT_T,  6'd1,  PT_NEG_ONE,     1'b0);
    add_item(cheb_pkg::ACT_T,  6'd63, PT_NEG_ONE,     1'b0);
    add_item(cheb_pkg::ACT_T,  6'd63, '0,             1'b0);
    add_item(cheb_pkg::ACT_T,  6'd7,  PT_HALF,        1'b0);
    add_item(cheb_pkg::ACT_U,  6'd0,  '0,             1'b0);
    add_item(cheb_pkg::ACT_U,  6'd1,  PT_NEG_ONE,     1'b0);
    add_item(cheb_pkg::ACT_U,  6'd2,  PT_HALF,        1'b0);
    add_item(cheb_pkg::ACT_U,  6'd63, PT_ONE,         1'b0);
    add_item(cheb_pkg::ACT_U,  6'd63, PT_NEG_ONE,     1'b0);
    add_item(cheb_pkg::ACT_DU, 6'd5,  PT_ONE,         1'b0);
    add_item(cheb_pkg::ACT_DU, 6'd63, PT_NEG_ONE,     1'b0);
    add_item(cheb_pkg::ACT_DU, 6'd0,  '0,             1'b0);
    add_item(cheb_pkg::ACT_DU, 6'd63, '0,             1'b0);
    add_item(cheb_pkg::ACT_DU, 6'd5,  PT_HALF,        1'b0);
    add_item(cheb_pkg::ACT_DU, 6'd63, PT_ONE - 1,     1'b0);
    add_item(cheb_pkg::ACT_DU, 6'd63, PT_NEG_ONE + 1, 1'b0);
    // Points far outside -1..1 drive the recurrence into saturation.
    add_item(cheb_pkg::ACT_T,  6'd63, 32'h7FFF_FFFF,  1'b0);
    add_item(cheb_pkg::ACT_U,  6'd63, 32'h8000_0000,  1'b0);
    add_item(cheb_pkg::ACT_DU, 6'd63, 32'h7FFF_FFFF,  1'b0);
    add_item(cheb_pkg::ACT_DU, 6'd1,  32'h8000_0000,  1'b0);
    add_item(ACT_NONE,         6'd63, 32'hFFFF_FFFF,  1'b0);
    add_item(ACT_NONE,         6'd0,  '0,             1'b0);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      sel = int'($urandom_range(99));
      if (sel < 65)
        pt = $urandom_range(32'h8000_0000) - PT_ONE;
      else if (sel < 80)
        pt = PT_ONE - $urandom_range(64);
      else if (sel < 92)
        pt = $urandom();
      else
        pt = $urandom_range(255) - 128;
      // Mirror the near-endpoint points to cover x = -1 as well.
      if (sel >= 65 && sel < 80 && $urandom_range(1) == 1)
        pt = -pt;

      sel = int'($urandom_range(99));
      if (sel < 30)      act = cheb_pkg::ACT_T;
      else if (sel < 60) act = cheb_pkg::ACT_U;
      else if (sel < 95) act = cheb_pkg::ACT_DU;
      else               act = ACT_NONE;

      // Keep most degrees small; the top degrees are slow.
      deg = DEG_W'(($urandom_range(99) < 70) ? $urandom_range(15) : $urandom_range(63));

      add_item(act, deg, pt, i == 0 || $urandom_range(59) == 0);
    end
    total_items = stim_items_q.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cnt != total_items || poly_results_q.size() != 0)
      @(posedge clk_i);
    // Let any stray result show up before judging.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && poly_results_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/cheb_pkg.sv
hdl/chebyshev_polynomial_evaluator.sv
dv/tb_top.sv
